@@ rtl/mm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types, constants and helpers for the fixed-point matrix multiply core.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int MaxDim   = 8;
  localparam int IdxW     = $clog2(MaxDim);
  localparam int DimW     = 4;
  localparam int DataW    = 32;
  localparam int FracBits = 16;
  localparam int ProdW    = 2 * DataW;
  localparam int AccW     = ProdW + IdxW + 1;
  localparam int CellCntW = $clog2(MaxDim + 1);

  typedef enum logic [1:0] {
    CMD_WR_LEFT  = 2'd0,
    CMD_WR_RIGHT = 2'd1,
    CMD_START    = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_LEFT_ROWS  = 2'd0,
    REG_LEFT_COLS  = 2'd1,
    REG_RIGHT_ROWS = 2'd2,
    REG_RIGHT_COLS = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DRAIN,
    ST_ERROR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             clear;
    logic             mac_en;
    logic             shift_en;
  } cell_ctrl_t;

  function automatic logic [CellCntW-1:0] clamp_dim(input logic [DimW-1:0] d);
    logic [CellCntW-1:0] r;
    if (d == '0) r = CellCntW'(1);
    else if (d > DimW'(MaxDim)) r = CellCntW'(MaxDim);
    else r = CellCntW'(d);
    return r;
  endfunction

  function automatic logic [DataW-1:0] round_sat(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] t;
    logic signed [AccW-1:0] maxv;
    logic signed [AccW-1:0] minv;
    logic [DataW-1:0]       r;
    maxv = AccW'(signed'({1'b0, {(DataW-1){1'b1}}}));
    minv = -maxv - AccW'(1);
    if (FracBits > 0) t = (acc + (AccW'(1) <<< (FracBits - 1))) >>> FracBits;
    else t = acc;
    if (t > maxv) r = maxv[DataW-1:0];
    else if (t < minv) r = minv[DataW-1:0];
    else r = t[DataW-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mm_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mm_cell
// One column lane: multiply-accumulate of a broadcast left value with a right
// value, and a shift stage that hands finished sums to the next cell.
// ----------------------------------------------------------------------------
module mm_cell (
  input  wire                                clk,
  input  wire mm_pkg::cell_ctrl_t            ctrl,
  input  wire logic signed [mm_pkg::DataW-1:0] a_in,
  input  wire logic signed [mm_pkg::DataW-1:0] b_in,
  input  wire logic signed [mm_pkg::AccW-1:0]  shift_in,
  output logic signed [mm_pkg::AccW-1:0]       shift_out
);
  import mm_pkg::*;

  logic signed [ProdW-1:0] prod_r;
  logic                    prod_v_r;
  logic signed [AccW-1:0]  acc_r;

  always_ff @(posedge clk) begin
    prod_r   <= a_in * b_in;
    prod_v_r <= ctrl.mac_en;
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + AccW'(prod_r);
    end else if (ctrl.shift_en) begin
      acc_r <= shift_in;
    end
  end

  assign shift_out = acc_r;

endmodule

`default_nettype wire

@@ rtl/matrix_multiply_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_core
// Row-at-a-time matrix multiply over a chain of eight MAC cells.
// ----------------------------------------------------------------------------
// A start runs per output row a MAC phase over the K terms (load, then drain)
// and then an emit phase of N words; the last word ends the run. A dimension
// error gives its result in the cycle after start. busy covers the run.
// Reset (rst_n low, synchronous) sets all dimensions to 1 and idles; the
// stores are not cleared. Results cannot be stalled by the receiver.
module matrix_multiply_core (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  output logic                                  busy,
  input  wire logic [1:0]                       in_command,
  input  wire logic [2:0]                       in_row_index,
  input  wire logic [2:0]                       in_col_index,
  input  wire logic signed [31:0]               in_element_value,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [3:0]                       cfg_data,
  output logic                                  out_strobe,
  output logic [2:0]                            out_out_row,
  output logic [2:0]                            out_out_col,
  output logic signed [31:0]                    out_product_value,
  output logic                                  out_size_error,
  output logic                                  out_last
);
  import mm_pkg::*;

  logic [DimW-1:0] lrows_r, lcols_r, rrows_r, rcols_r;
  logic [DataW-1:0] left_mem [MaxDim*MaxDim];
  logic [DataW-1:0] right_mem [MaxDim][MaxDim];

  state_t state_r, state_nxt;
  logic [IdxW-1:0]     i_r, i_nxt;
  logic [CellCntW-1:0] g_r, g_nxt;
  logic [CellCntW-1:0] e_r, e_nxt;
  logic [CellCntW-1:0] m_r, k_r, n_r;
  logic                accept;
  cell_ctrl_t          ctrl;
  logic [DataW-1:0]    a_r;
  logic [DataW-1:0]    b_r [MaxDim];
  logic signed [AccW-1:0] chain [MaxDim+1];

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lrows_r <= DimW'(1);
      lcols_r <= DimW'(1);
      rrows_r <= DimW'(1);
      rcols_r <= DimW'(1);
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LEFT_ROWS:  lrows_r <= cfg_data;
        REG_LEFT_COLS:  lcols_r <= cfg_data;
        REG_RIGHT_ROWS: rrows_r <= cfg_data;
        REG_RIGHT_COLS: rcols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd_t'(in_command) == CMD_WR_LEFT) begin
      left_mem[{in_row_index, in_col_index}] <= in_element_value;
    end
    a_r <= left_mem[{i_r, g_r[IdxW-1:0]}];
  end

  for (genvar c = 0; c < MaxDim; c++) begin : g_rmem
    always_ff @(posedge clk) begin
      if (accept && cmd_t'(in_command) == CMD_WR_RIGHT
          && in_col_index == IdxW'(c)) begin
        right_mem[c][in_row_index] <= in_element_value;
      end
      b_r[c] <= right_mem[c][g_r[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_r <= clamp_dim(lrows_r);
      k_r <= clamp_dim(lcols_r);
      n_r <= clamp_dim(rcols_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    g_nxt = g_r;
    e_nxt = e_r;
    unique case (state_r)
      ST_IDLE: begin
        i_nxt = '0;
        g_nxt = '0;
        if (accept && cmd_t'(in_command) == CMD_START) begin
          if (clamp_dim(lcols_r) != clamp_dim(rrows_r)) state_nxt = ST_ERROR;
          else state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        g_nxt = g_r + CellCntW'(1);
        if (g_r == k_r - CellCntW'(1)) begin
          state_nxt = ST_DRAIN;
          e_nxt = '0;
        end
      end
      ST_DRAIN: begin
        e_nxt = e_r + CellCntW'(1);
        if (e_r == CellCntW'(2)) begin
          state_nxt = ST_EMIT;
          e_nxt = '0;
        end
      end
      ST_EMIT: begin
        e_nxt = e_r + CellCntW'(1);
        if (e_r == n_r - CellCntW'(1)) begin
          g_nxt = '0;
          if ({1'b0, i_r} == CellCntW'(m_r - CellCntW'(1))) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt = i_r + IdxW'(1);
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_ERROR: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r <= '0;
      g_r <= '0;
      e_r <= '0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt;
      g_r <= g_nxt;
      e_r <= e_nxt;
    end
  end

  logic mac_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) mac_d_r <= 1'b0;
    else mac_d_r <= (state_r == ST_LOAD);
  end

  always_comb begin
    ctrl.clear    = (state_r == ST_IDLE) || (state_r == ST_EMIT && e_r == n_r - CellCntW'(1));
    ctrl.mac_en   = mac_d_r;
    ctrl.shift_en = (state_r == ST_EMIT);
  end

  assign chain[MaxDim] = '0;
  for (genvar c = 0; c < MaxDim; c++) begin : g_cell
    mm_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .a_in     (signed'(a_r)),
      .b_in     (signed'(b_r[c])),
      .shift_in (chain[c+1]),
      .shift_out(chain[c])
    );
  end

  always_comb begin
    busy              = (state_r != ST_IDLE);
    out_strobe        = (state_r == ST_EMIT) || (state_r == ST_ERROR);
    out_size_error    = (state_r == ST_ERROR);
    out_out_row       = (state_r == ST_EMIT) ? i_r : '0;
    out_out_col       = (state_r == ST_EMIT) ? e_r[IdxW-1:0] : '0;
    out_product_value = (state_r == ST_EMIT) ? signed'(round_sat(chain[0])) : '0;
    out_last          = (state_r == ST_ERROR) ||
                        (state_r == ST_EMIT && e_r == n_r - CellCntW'(1) &&
                         {1'b0, i_r} == CellCntW'(m_r - CellCntW'(1)));
  end

endmodule

`default_nettype wire

@@ rtl/mm_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mm_checker
// Port-level checks on the matrix multiply core.
// ----------------------------------------------------------------------------
module mm_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       busy,
  input wire       out_strobe,
  input wire       out_size_error,
  input wire       out_last
);
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_size_error |-> out_last) else $error("error word without last");
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("word while idle");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !busy) else $error("busy after last word");
endmodule

bind matrix_multiply_core mm_checker u_mm_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_strobe(out_strobe),
  .out_size_error(out_size_error), .out_last(out_last)
);

`default_nettype wire

@@ verif/tb_matrix_multiply_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply core testbench
// Loads left and right matrices element by element, programs the four
// dimension registers, issues starts and checks every product word (and the
// dimension error word) against an in-bench fixed-point matrix predictor.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_core;
  import mm_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_command = '0;
  logic [2:0]         in_row_index = '0;
  logic [2:0]         in_col_index = '0;
  logic signed [31:0] in_element_value = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [3:0]         cfg_data = '0;
  logic               out_strobe;
  logic [2:0]         out_out_row;
  logic [2:0]         out_out_col;
  logic signed [31:0] out_product_value;
  logic               out_size_error;
  logic               out_last;

  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        size_error;
    logic        last;
  } product_word_t;

  product_word_t     product_q[$];
  logic [31:0]       left_mem[8][8];
  logic [31:0]       right_mem[8][8];
  logic [3:0]        dim_reg[4];
  int                errors = 0;
  int                n_items = 0;
  int                n_words = 0;
  int                n_starts = 0;
  int                n_dim_errors = 0;
  int                idle_cycles = 0;
  int                sender_idle_pct = 0;

  always #5 clk = ~clk;

  matrix_multiply_core u_dut (
    .clk, .rst_n, .start, .busy, .in_command, .in_row_index, .in_col_index,
    .in_element_value, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .out_strobe, .out_out_row, .out_out_col, .out_product_value,
    .out_size_error, .out_last
  );

  function automatic int eff_dim(logic [3:0] d);
    if (d == 0) return 1;
    if (d > MaxDim) return MaxDim;
    return int'(d);
  endfunction

  function automatic logic [31:0] sat_q16(logic signed [127:0] acc);
    logic signed [127:0] t;
    t = (acc + (128'sd1 <<< (FracBits - 1))) >>> FracBits;
    if (t > 128'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (t < -128'sh8000_0000) return 32'h8000_0000;
    return t[31:0];
  endfunction

  task automatic predict_matrix(logic [1:0] cmd, logic [2:0] r, logic [2:0] c,
                                logic [31:0] v);
    int m, kl, kr, n;
    logic signed [127:0] acc;
    product_word_t w;
    case (cmd)
      CMD_WR_LEFT: left_mem[r][c] = v;
      CMD_WR_RIGHT: right_mem[r][c] = v;
      CMD_START: begin
        n_starts++;
        m = eff_dim(dim_reg[REG_LEFT_ROWS]);
        kl = eff_dim(dim_reg[REG_LEFT_COLS]);
        kr = eff_dim(dim_reg[REG_RIGHT_ROWS]);
        n = eff_dim(dim_reg[REG_RIGHT_COLS]);
        if (kl != kr) begin
          w = '{row: 0, col: 0, value: 0, size_error: 1, last: 1};
          product_q.push_back(w);
          n_dim_errors++;
        end else begin
          for (int i = 0; i < m; i++)
            for (int k = 0; k < n; k++) begin
              acc = '0;
              for (int g = 0; g < kl; g++)
                acc += 128'(signed'(left_mem[i][g])) * 128'(signed'(right_mem[g][k]));
              w.row = i[2:0];
              w.col = k[2:0];
              w.value = sat_q16(acc);
              w.size_error = 1'b0;
              w.last = (i == m - 1) && (k == n - 1);
              product_q.push_back(w);
            end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    product_word_t e;
    if (rst_n && out_strobe) begin
      n_words++;
      if (product_q.size() == 0) begin
        $error("unexpected word row=%0d col=%0d", out_out_row, out_out_col);
        errors++;
      end else begin
        e = product_q.pop_front();
        if (out_out_row !== e.row) begin
          $error("out_row exp %0d got %0d", e.row, out_out_row); errors++;
        end
        if (out_out_col !== e.col) begin
          $error("out_col exp %0d got %0d", e.col, out_out_col); errors++;
        end
        if (out_product_value !== e.value) begin
          $error("product_value exp %h got %h", e.value, out_product_value); errors++;
        end
        if (out_size_error !== e.size_error) begin
          $error("size_error exp %b got %b", e.size_error, out_size_error); errors++;
        end
        if (out_last !== e.last) begin
          $error("last exp %b got %b", e.last, out_last); errors++;
        end
      end
    end
  end

  // watchdog: cycles with no accepted item, configuration write or word
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [2:0] r, logic [2:0] c,
                           logic [31:0] v);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(negedge clk);
    end
    in_command <= cmd;
    in_row_index <= r;
    in_col_index <= c;
    in_element_value <= v;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_matrix(cmd, r, c, v);
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain_products();
    start <= 1'b0;
    while (product_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_dim(reg_idx_t idx, logic [3:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    dim_reg[idx] = d;
    @(negedge clk);
  endtask

  task automatic set_dims(logic [3:0] m, logic [3:0] k, logic [3:0] kr, logic [3:0] n);
    drain_products();
    write_dim(REG_LEFT_ROWS, m);
    write_dim(REG_LEFT_COLS, k);
    write_dim(REG_RIGHT_ROWS, kr);
    write_dim(REG_RIGHT_COLS, n);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(2047)) - 1024) <<< 16;
      3: return 32'($urandom_range(65535)) - 32768;
      default: return $urandom;
    endcase
  endfunction

  task automatic fill_all(bit extremes);
    for (int r = 0; r < MaxDim; r++)
      for (int c = 0; c < MaxDim; c++) begin
        send_item(CMD_WR_LEFT, r[2:0], c[2:0], extremes ? 32'h7FFF_FFFF : rand_value());
        send_item(CMD_WR_RIGHT, r[2:0], c[2:0], extremes ? 32'h8000_0000 : rand_value());
      end
  endtask

  task automatic test_directed();
    send_item(CMD_WR_LEFT, 0, 0, 32'h0001_8000);
    send_item(CMD_WR_RIGHT, 0, 0, 32'h0000_8000);
    send_item(CMD_START, 0, 0, 0);
    send_item(CMD_WR_LEFT, 0, 0, 32'hFFFF_8000);
    send_item(CMD_START, 7, 7, 32'hFFFF_FFFF);
    send_item(CMD_NOP, 7, 7, 32'hFFFF_FFFF);
    send_item(CMD_WR_LEFT, 0, 0, 32'h7FFF_FFFF);
    send_item(CMD_WR_RIGHT, 0, 0, 32'h7FFF_FFFF);
    send_item(CMD_START, 0, 0, 0);
    send_item(CMD_WR_RIGHT, 0, 0, 32'h8000_0000);
    send_item(CMD_START, 0, 0, 0);
    set_dims(1, 2, 1, 1);
    send_item(CMD_START, 0, 0, 0);
    set_dims(0, 0, 0, 0);
    send_item(CMD_START, 0, 0, 0);
  endtask

  task automatic test_extremes();
    fill_all(1'b1);
    set_dims(8, 8, 8, 8);
    send_item(CMD_START, 0, 0, 0);
    set_dims(15, 15, 15, 15);
    send_item(CMD_START, 0, 0, 0);
    set_dims(8, 9, 8, 1);
    send_item(CMD_START, 0, 0, 0);
  endtask

  task automatic test_random(bit refill, int pct);
    int m, k, n;
    sender_idle_pct = pct;
    if (refill) fill_all(1'b0);
    repeat (3) begin
      m = $urandom_range(4, 1); k = $urandom_range(4, 1); n = $urandom_range(4, 1);
      set_dims(4'(m), 4'(k), ($urandom_range(5) == 0) ? 4'(k % 8 + 1) : 4'(k), 4'(n));
      repeat (25) begin
        case ($urandom_range(9))
          0: send_item(CMD_START, 3'($urandom), 3'($urandom), $urandom);
          1: send_item(CMD_NOP, 3'($urandom), 3'($urandom), $urandom);
          2, 3, 4, 5: send_item(CMD_WR_LEFT, 3'($urandom), 3'($urandom), rand_value());
          default: send_item(CMD_WR_RIGHT, 3'($urandom), 3'($urandom), rand_value());
        endcase
      end
      send_item(CMD_START, 0, 0, 0);
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) dim_reg[i] = 4'd1;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_extremes();
    test_random(1'b1, 0);
    test_random(1'b0, 55);
    test_random(1'b0, 33);
    drain_products();
    $display("Covered %0d items, %0d starts (%0d dimension errors), %0d words checked.",
             n_items, n_starts, n_dim_errors, n_words);
    if (errors == 0 && product_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

@@ files.f @@
rtl/mm_pkg.sv
rtl/mm_cell.sv
rtl/matrix_multiply_core.sv
rtl/mm_checker.sv
verif/tb_matrix_multiply_core.sv
